>>> rtl/uer_pkg.sv
package uer_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [1:0] REG_RISE_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH     = 2'd2;

    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd15;
    localparam logic [19:0] RISE_TIMEOUT_RST  = 20'd600000;
    localparam logic [15:0] MAX_WIDTH_RST     = 16'd60000;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_RISE_TMO    = 2'd1;
    localparam logic [1:0] ST_NO_OBSTACLE = 2'd2;

    localparam logic [15:0] HIGH_CAP = 16'hFFFF;

    // floor(x / 58) = (x * CM_RECIP) >> CM_SHIFT for 15-bit x
    localparam logic [15:0] CM_RECIP = 16'd36158;
    localparam int unsigned CM_SHIFT = 21;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic echo;
    } t_in_word;

    typedef struct packed {
        logic               trig;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic [14:0]        half_width;
        logic signed [15:0] distance_cm;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [19:0] rise_timeout;
        logic [15:0] max_width;
    } t_cfg;

endpackage

>>> rtl/ultrasonic_echo_ranger.sv
// an accepted input word is held in the input register, and its result word then in the result register
// throughput: one word per cycle while i_out_ready is high, limited by the input and result registers
// every input word gives exactly one result word
// reset (i_rst_n low, synchronous): idle phase, counters and held distance
// cleared, registers back to their default values, both pipeline stages empty
module ultrasonic_echo_ranger (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  uer_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output uer_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]  paddr,
    input  logic [uer_pkg::DATA_W-1:0]  pwdata,
    output logic [uer_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    uer_pkg::t_cfg      cfg;
    uer_pkg::t_in_word  r_in_word;
    logic               r_in_valid;
    uer_pkg::t_out_word r_out_word;
    logic               r_out_valid;
    uer_pkg::t_out_word res;
    logic               step;
    logic               in_take;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    uer_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    uer_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !step);
            r_out_valid <= step || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (step) begin
            r_out_word <= res;
        end
    end

endmodule

>>> rtl/uer_regs.sv
module uer_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]  paddr,
    input  logic [uer_pkg::DATA_W-1:0]  pwdata,
    output logic [uer_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output uer_pkg::t_cfg               o_cfg
);

    uer_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
            r_cfg.rise_timeout  <= uer_pkg::RISE_TIMEOUT_RST;
            r_cfg.max_width     <= uer_pkg::MAX_WIDTH_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                uer_pkg::REG_TRIGGER_TICKS: r_cfg.trigger_ticks <= pwdata[7:0];
                uer_pkg::REG_RISE_TIMEOUT:  r_cfg.rise_timeout  <= pwdata[19:0];
                uer_pkg::REG_MAX_WIDTH:     r_cfg.max_width     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            uer_pkg::REG_TRIGGER_TICKS: prdata = {24'd0, r_cfg.trigger_ticks};
            uer_pkg::REG_RISE_TIMEOUT:  prdata = {12'd0, r_cfg.rise_timeout};
            uer_pkg::REG_MAX_WIDTH:     prdata = {16'd0, r_cfg.max_width};
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> rtl/uer_fsm.sv
module uer_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  uer_pkg::t_in_word i_word,
    input  uer_pkg::t_cfg     i_cfg,
    output uer_pkg::t_out_word o_res
);

    uer_pkg::t_phase    r_phase;
    uer_pkg::t_phase    n_phase;
    logic [19:0]        r_wait_count;
    logic [19:0]        n_wait_count;
    logic [15:0]        r_high_count;
    logic [15:0]        n_high_count;
    logic signed [15:0] r_held;
    logic signed [15:0] n_held;

    uer_pkg::t_phase    cur_phase;
    logic [19:0]        cur_wait;
    logic [19:0]        wait_inc;
    logic [15:0]        high_inc;
    logic [14:0]        hw_cur;
    logic [30:0]        prod;
    logic [9:0]         quot;
    logic signed [15:0] cm_dist;
    logic               trig;
    logic               done;
    logic [1:0]         status;
    logic [14:0]        hw;

    // distance from the stored count, used on the falling edge
    assign hw_cur = r_high_count[15:1];
    assign prod   = 31'(hw_cur) * 31'(uer_pkg::CM_RECIP);
    assign quot   = prod[uer_pkg::CM_SHIFT +: 10];

    always_comb begin
        if (hw_cur == 15'd0) begin
            cm_dist = -16'sd1;
        end else if (quot == 10'd0) begin
            cm_dist = 16'sd0;
        end else begin
            cm_dist = signed'({6'd0, quot - 10'd1});
        end
    end

    always_comb begin
        cur_phase = r_phase;
        cur_wait  = r_wait_count;
        if (r_phase == uer_pkg::PH_IDLE && i_word.start_req) begin
            cur_phase = uer_pkg::PH_TRIG;
            cur_wait  = '0;
        end
        wait_inc = cur_wait + 20'd1;
        high_inc = (r_high_count != uer_pkg::HIGH_CAP) ? r_high_count + 16'd1
                                                         : r_high_count;

        n_phase      = cur_phase;
        n_wait_count = cur_wait;
        n_high_count = r_high_count;
        n_held       = r_held;
        trig         = 1'b0;
        done         = 1'b0;
        status       = uer_pkg::ST_OK;
        hw           = '0;

        unique case (cur_phase)
            uer_pkg::PH_IDLE: ;
            uer_pkg::PH_TRIG: begin
                trig         = 1'b1;
                n_wait_count = wait_inc;
                if (wait_inc >= 20'(i_cfg.trigger_ticks)) begin
                    n_phase      = uer_pkg::PH_WAIT;
                    n_wait_count = '0;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (i_word.echo) begin
                    n_phase      = uer_pkg::PH_MEAS;
                    n_high_count = 16'd1;
                    if (i_cfg.max_width == 16'd0) begin
                        n_phase = uer_pkg::PH_IDLE;
                        done    = 1'b1;
                        status  = uer_pkg::ST_NO_OBSTACLE;
                    end
                end else begin
                    n_wait_count = wait_inc;
                    if (wait_inc >= i_cfg.rise_timeout) begin
                        n_phase = uer_pkg::PH_IDLE;
                        done    = 1'b1;
                        status  = uer_pkg::ST_RISE_TMO;
                    end
                end
            end
            uer_pkg::PH_MEAS: begin
                if (i_word.echo) begin
                    n_high_count = high_inc;
                    if (high_inc > i_cfg.max_width || high_inc == uer_pkg::HIGH_CAP) begin
                        n_phase = uer_pkg::PH_IDLE;
                        done    = 1'b1;
                        status  = uer_pkg::ST_NO_OBSTACLE;
                        hw      = high_inc[15:1];
                    end
                end else begin
                    n_phase = uer_pkg::PH_IDLE;
                    done    = 1'b1;
                    hw      = hw_cur;
                    if (r_high_count > i_cfg.max_width
                            || r_high_count == uer_pkg::HIGH_CAP) begin
                        status = uer_pkg::ST_NO_OBSTACLE;
                    end else begin
                        n_held = cm_dist;
                    end
                end
            end
            default: n_phase = uer_pkg::PH_IDLE;
        endcase

        o_res.trig        = trig;
        o_res.busy_res    = (n_phase != uer_pkg::PH_IDLE);
        o_res.done_res    = done;
        o_res.status      = status;
        o_res.half_width  = hw;
        o_res.distance_cm = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uer_pkg::PH_IDLE;
            r_wait_count <= '0;
            r_high_count <= '0;
            r_held       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_high_count <= n_high_count;
            r_held       <= n_held;
        end
    end

endmodule

>>> test/uer_checker.sv
`timescale 1ns / 1ps
module uer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  uer_pkg::t_in_word            i_in_word,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  uer_pkg::t_out_word           i_out_word,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [uer_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [uer_pkg::DATA_W-1:0]   i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import uer_pkg::*;

    localparam int unsigned TICKS_PER_CM = 58;
    localparam int          PRINT_LIMIT  = 30;

    t_phase      rng_phase;
    logic [19:0] tick_cnt;
    logic [15:0] echo_cnt;
    logic signed [15:0] held_cm;
    logic [7:0]  cfg_trig;
    logic [19:0] cfg_rise;
    logic [15:0] cfg_max;

    t_out_word   expected_words[$];
    t_out_word   want_word;
    int          mismatch_cnt = 0;

    assign o_fail_count = mismatch_cnt;

    function automatic logic [15:0] cm_of(input logic [14:0] hw);
        if (hw == 15'd0)
            return 16'hFFFF;
        if (hw < 15'(TICKS_PER_CM))
            return 16'd0;
        return 16'(hw / 15'(TICKS_PER_CM) - 15'd1);
    endfunction

    // advances the ranger by one tick and returns the word it should report
    function automatic t_out_word range_tick(input t_in_word w);
        t_out_word r;
        r = '0;
        if (rng_phase == PH_IDLE && w.start_req) begin
            rng_phase = PH_TRIG;
            tick_cnt  = '0;
        end
        case (rng_phase)
            PH_TRIG: begin
                r.trig   = 1'b1;
                tick_cnt = tick_cnt + 20'd1;
                if (tick_cnt >= {12'd0, cfg_trig}) begin
                    rng_phase = PH_WAIT;
                    tick_cnt  = '0;
                end
            end
            PH_WAIT: begin
                if (w.echo) begin
                    rng_phase = PH_MEAS;
                    echo_cnt  = 16'd1;
                    if (echo_cnt > cfg_max) begin
                        rng_phase    = PH_IDLE;
                        r.done_res   = 1'b1;
                        r.status     = ST_NO_OBSTACLE;
                        r.half_width = echo_cnt[15:1];
                    end
                end else begin
                    tick_cnt = tick_cnt + 20'd1;
                    if (tick_cnt >= cfg_rise) begin
                        rng_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                        r.status   = ST_RISE_TMO;
                    end
                end
            end
            PH_MEAS: begin
                if (w.echo) begin
                    if (echo_cnt != HIGH_CAP)
                        echo_cnt = echo_cnt + 16'd1;
                    if (echo_cnt > cfg_max || echo_cnt == HIGH_CAP) begin
                        rng_phase    = PH_IDLE;
                        r.done_res   = 1'b1;
                        r.status     = ST_NO_OBSTACLE;
                        r.half_width = echo_cnt[15:1];
                    end
                end else begin
                    rng_phase    = PH_IDLE;
                    r.done_res   = 1'b1;
                    r.half_width = echo_cnt[15:1];
                    if (echo_cnt > cfg_max || echo_cnt == HIGH_CAP) begin
                        r.status = ST_NO_OBSTACLE;
                    end else begin
                        r.status = ST_OK;
                        held_cm  = cm_of(echo_cnt[15:1]);
                    end
                end
            end
            default: ;
        endcase
        r.busy_res    = (rng_phase != PH_IDLE);
        r.distance_cm = held_cm;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rng_phase = PH_IDLE;
            tick_cnt  = '0;
            echo_cnt  = '0;
            held_cm   = '0;
            cfg_trig  = TRIGGER_TICKS_RST;
            cfg_rise  = RISE_TIMEOUT_RST;
            cfg_max   = MAX_WIDTH_RST;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[uer_pkg::ADDR_W-1:2])
                    REG_TRIGGER_TICKS: cfg_trig = i_pwdata[7:0];
                    REG_RISE_TIMEOUT:  cfg_rise = i_pwdata[19:0];
                    REG_MAX_WIDTH:     cfg_max  = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(range_tick(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", 0, 0);
                end else begin
                    want_word = expected_words.pop_front();
                    if (i_out_word.trig !== want_word.trig)
                        report_mismatch("trig", i_out_word.trig, want_word.trig);
                    if (i_out_word.busy_res !== want_word.busy_res)
                        report_mismatch("busy_res", i_out_word.busy_res, want_word.busy_res);
                    if (i_out_word.done_res !== want_word.done_res)
                        report_mismatch("done_res", i_out_word.done_res, want_word.done_res);
                    if (i_out_word.status !== want_word.status)
                        report_mismatch("status", i_out_word.status, want_word.status);
                    if (i_out_word.half_width !== want_word.half_width)
                        report_mismatch("half_width", i_out_word.half_width,
                                        want_word.half_width);
                    if (i_out_word.distance_cm !== want_word.distance_cm)
                        report_mismatch("distance_cm", int'(i_out_word.distance_cm),
                                        int'(want_word.distance_cm));
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 64;
    localparam int RANDOM_WORDS   = 200;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_word           i_in_word   = '0;
    logic               i_out_ready = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asks     = 0;
    int cur_trig      = TRIGGER_TICKS_RST;
    int cur_rise      = RISE_TIMEOUT_RST;
    int cur_max       = MAX_WIDTH_RST;
    int words_sent    = 0;
    int pings         = 0;
    int quiet_cycles  = 0;

    ultrasonic_echo_ranger i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    uer_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold on request
    initial begin
        int hold_done;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic send_word(input logic req, input logic lvl);
        t_in_word w;
        w.start_req = req;
        w.echo      = lvl;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int trig_len, input int rise_len, input int max_len);
        drain_results();
        write_reg(REG_TRIGGER_TICKS, trig_len);
        write_reg(REG_RISE_TIMEOUT, rise_len);
        write_reg(REG_MAX_WIDTH, max_len);
        cur_trig = trig_len;
        cur_rise = rise_len;
        cur_max  = max_len;
    endtask

    // start, trigger, low wait, echo pulse, falling edge; a long wait times out
    task automatic run_ping(input int low_ticks, input int high_ticks);
        int trig_eff;
        int rise_eff;
        trig_eff = at_least_one(cur_trig);
        rise_eff = at_least_one(cur_rise);
        send_word(1'b1, 1'($urandom_range(1)));
        for (int k = 1; k < trig_eff; k++)
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
        for (int k = 0; k < low_ticks && k < rise_eff; k++)
            send_word(1'($urandom_range(1)), 1'b0);
        if (low_ticks < rise_eff) begin
            for (int k = 0; k < high_ticks; k++)
                send_word(1'b0, 1'b1);
            send_word(1'b0, 1'b0);
        end
        pings++;
    endtask

    // random words, then enough quiet ticks to bring the ranger back to idle
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
        for (int k = 0; k < at_least_one(cur_trig) + at_least_one(cur_rise) + 1; k++)
            send_word(1'b0, 1'b0);
    endtask

    task automatic random_ping();
        int rise_eff;
        int low_ticks;
        int high_ticks;
        int sel;
        rise_eff  = at_least_one(cur_rise);
        low_ticks = $urandom_range(0, (rise_eff - 1 < 20) ? rise_eff - 1 : 20);
        sel = $urandom_range(99);
        if (sel < 75)
            high_ticks = $urandom_range(1, 12);
        else if (sel < 90)
            high_ticks = cur_max + $urandom_range(0, 2) - 1;
        else
            high_ticks = $urandom_range(116, 240);
        if (high_ticks < 1)
            high_ticks = 1;
        run_ping(low_ticks, high_ticks);
    endtask

    initial begin
        int phase_base;
        int pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults; single high tick gives distance -1
        run_ping(3, 1);
        run_ping(2, 5);
        set_config(1, 1, 1);
        run_ping(0, 1);
        run_ping(0, 2);
        run_ping(1, 0);
        // zero registers act as one, zero max width ends on the rising tick
        set_config(0, 0, 0);
        run_ping(0, 1);
        run_ping(1, 0);
        run_ping(0, 3);
        // largest timeout and width limits
        set_config(2, 1048575, 65535);
        run_ping(4, 20);
        set_config(2, 9, 30);
        run_ping(0, 30);
        run_ping(0, 31);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
                1: begin send_idle_pct <= 76; stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  stall_pct <= 76; end
                default: begin send_idle_pct <= 8; stall_pct <= 8; end
            endcase
            set_config($urandom_range(0, 6), $urandom_range(0, 30),
                       (ph % 2 == 0) ? $urandom_range(60, 130) : $urandom_range(0, 16));
            phase_base = words_sent;
            if (ph == 0) begin
                hold_asks <= hold_asks + 1;
                run_ping(at_least_one(cur_rise) - 1, 8);
            end
            while (words_sent - phase_base < RANDOM_WORDS / 4) begin
                if (ph == 1 && words_sent - phase_base >= RANDOM_WORDS / 8
                        && words_sent - phase_base < RANDOM_WORDS / 8 + 30)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 10)
                    noise_burst();
                else if (pick < 22)
                    run_ping(at_least_one(cur_rise), 0);
                else
                    random_ping();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d input words in %0d measurements over four idling modes",
                 words_sent, pings);
        $display("registers at zero, minimum and large values, plus a long output hold");
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
